[sv/ald_pkg.sv]
// Shared constants, codes and types of the adjacent line dedup block.
`timescale 1ns / 1ps
package ald_pkg;

	// Line storage geometry: two banks of MAX_LINE bytes
	localparam int MAX_LINE = 8192;
	localparam int POS_W    = $clog2(MAX_LINE);
	localparam int ADDR_W   = POS_W + 1;
	localparam int DEPTH    = 2 * MAX_LINE;
	localparam logic [POS_W-1:0] LINE_LIMIT = POS_W'(MAX_LINE - 2);

	localparam int TEXT_W     = 8;
	localparam int COUNT_W    = 16;
	localparam int FIELDS_W   = 8;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIELDS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LETTERS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_SELECT  = 2'd2;

	// Modes
	localparam logic [MODE_W-1:0] MODE_UNIQUE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DUPS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PREFIX = 3'd4;

	// Characters
	localparam logic [TEXT_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [TEXT_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [TEXT_W-1:0] CH_TAB     = 8'd9;
	localparam logic [TEXT_W-1:0] CH_NUL     = 8'd0;

	// Key scanner phases
	localparam logic [1:0] PH_BLANK  = 2'd0;
	localparam logic [1:0] PH_WORD   = 2'd1;
	localparam logic [1:0] PH_LETTER = 2'd2;
	localparam logic [1:0] PH_KEY    = 2'd3;

	// Key compare outcome
	localparam logic [1:0] CMP_EXACT  = 2'd0;
	localparam logic [1:0] CMP_PREFIX = 2'd1;
	localparam logic [1:0] CMP_DIFF   = 2'd2;

	typedef struct packed {
		logic               print_line;
		logic               show_count;
		logic [COUNT_W-1:0] repeat_count;
		logic [POS_W-1:0]   line_length;
		logic               too_long_error;
	} result_t;

endpackage

[sv/ald_stream_if.sv]
// Valid/ready channel interfaces for text bytes and group results.
`timescale 1ns / 1ps
interface ald_byte_if;
	logic                         valid;
	logic                         ready;
	logic [ald_pkg::TEXT_W-1:0]   text_byte;
	logic                         end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ald_result_if;
	logic                          valid;
	logic                          ready;
	logic                          print_line;
	logic                          show_count;
	logic [ald_pkg::COUNT_W-1:0]   repeat_count;
	logic [ald_pkg::POS_W-1:0]     line_length;
	logic                          too_long_error;

	modport source (output valid, print_line, show_count, repeat_count, line_length,
		too_long_error, input ready);
	modport sink   (input valid, print_line, show_count, repeat_count, line_length,
		too_long_error, output ready);
endinterface

[sv/adjacent_line_dedup.sv]
// Top level of the adjacent duplicate line filter.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one text byte per item; a byte of 10 closes a line and
//   end_of_text flushes the held group (the byte is then ignored).
//   out_ch carries at most one result per item: the verdict, repeat count
//   and length of a closed group, or the too-long error after which the
//   block swallows every item until reset. The host emits the line text.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data).
// Throughput: one item per cycle, but see the exception and stall. The
//   key of the line being received is found and compared against the held
//   key while the bytes stream in: each byte costs one store write and one
//   store read, so a newline is settled in its own cycle. The result is
//   registered: it shows in the cycle after the closing item is accepted.
// Exception: a write to skip_fields or skip_letters while a line is partly
//   received rescans that line from the store, which holds off input until
//   the rescan is done.
// Reset: clears all control state and the configuration; the store is not
//   cleared, only written entries are ever read.
// Stall: while a result waits on out_ch, items are accepted only in the
//   cycle in which the receiver takes it.
module adjacent_line_dedup (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ald_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ald_pkg::CFG_DATA_W-1:0]   cfg_data,
	ald_byte_if.sink                         in_ch,
	ald_result_if.source                     out_ch
);
	import ald_pkg::*;

	// configuration
	logic [FIELDS_W-1:0] skip_fields_q;
	logic [POS_W-1:0]    skip_letters_q;
	logic [MODE_W-1:0]   mode_q;

	// group state
	logic               held_bank_q, held_bank_d;
	logic               have_held_q, have_held_d;
	logic [POS_W-1:0]   held_len_q, held_len_d;
	logic [POS_W-1:0]   held_key_q, held_key_d;
	logic [POS_W-1:0]   new_len_q, new_len_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               saw_q, saw_d;
	logic               halted_q, halted_d;
	logic               dirty_q, dirty_d;

	// key scanner / comparator
	logic [1:0]          phase_q, phase_d;
	logic [FIELDS_W-1:0] fc_q, fc_d;
	logic [POS_W-1:0]    lc_q, lc_d;
	logic [POS_W-1:0]    kidx_q, kidx_d;
	logic [POS_W-1:0]    kstart_q, kstart_d;
	logic                kfound_q, kfound_d;
	logic                decided_q, decided_d;
	logic [1:0]          outcome_q, outcome_d;
	logic                inrange_q, inrange_d;

	// rescan sequencer
	logic             rp_act_q, rp_act_d;
	logic [POS_W-1:0] rp_pos_q, rp_pos_d;
	logic             rp_vld_s1, rp_vld_d;
	logic [POS_W-1:0] rp_pos_s1, rp_pos_s1_d;

	// result register
	logic    out_valid_q;
	result_t res_q, res_d, rep;
	logic    res_load;

	// store
	logic              mem_we;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [TEXT_W-1:0] rd_a, rd_b;

	logic              in_fire, wbank, eng_clear, step_en;
	logic [TEXT_W-1:0] step_byte, c_cur;
	logic [POS_W-1:0]  step_pos, key_final;
	logic              fin_exact, fin_prefix, is_nl;
	logic [POS_W:0]    held_sum;

	assign in_ch.ready = !rp_act_q && !dirty_q && (!out_valid_q || out_ch.ready);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign wbank       = have_held_q ? ~held_bank_q : held_bank_q;
	assign is_nl       = in_ch.text_byte == CH_NEWLINE;

	// held byte at the current key index; past the held line it reads as 0
	assign c_cur     = inrange_q ? rd_a : CH_NUL;
	assign key_final = kfound_q ? kstart_q : new_len_q;
	// new key exhausted: exact if the held key ends here too
	assign fin_exact  = decided_q ? (outcome_q == CMP_EXACT) : (c_cur == CH_NUL);
	assign fin_prefix = decided_q && (outcome_q == CMP_PREFIX);

	always_comb begin
		rep = '0;
		rep.print_line = 1'b1;
		if (mode_q == MODE_UNIQUE) begin
			rep.print_line = !saw_q;
		end else if (mode_q == MODE_DUPS) begin
			rep.print_line = saw_q;
		end
		rep.show_count   = (mode_q == MODE_COUNT);
		rep.repeat_count = count_q;
		rep.line_length  = held_len_q;
	end

	// main control
	always_comb begin
		held_bank_d = held_bank_q;
		have_held_d = have_held_q;
		held_len_d  = held_len_q;
		held_key_d  = held_key_q;
		new_len_d   = new_len_q;
		count_d     = count_q;
		saw_d       = saw_q;
		halted_d    = halted_q;
		dirty_d     = dirty_q;
		rp_act_d    = rp_act_q;
		rp_pos_d    = rp_pos_q;
		rp_vld_d    = 1'b0;
		rp_pos_s1_d = rp_pos_s1;
		res_load    = 1'b0;
		res_d       = rep;
		mem_we      = 1'b0;
		eng_clear   = 1'b0;
		step_en     = 1'b0;
		step_byte   = in_ch.text_byte;
		step_pos    = new_len_q;

		if (halted_q) begin
			rp_act_d = 1'b0;
		end else if (dirty_q) begin
			// (re)start a rescan of the partial line under the new settings
			rp_act_d  = 1'b1;
			rp_pos_d  = '0;
			dirty_d   = 1'b0;
			eng_clear = 1'b1;
		end else if (rp_act_q) begin
			if (rp_vld_s1) begin
				step_en   = 1'b1;
				step_byte = rd_b;
				step_pos  = rp_pos_s1;
			end
			if (rp_pos_q < new_len_q) begin
				rp_vld_d    = 1'b1;
				rp_pos_s1_d = rp_pos_q;
				rp_pos_d    = rp_pos_q + 1'b1;
			end else if (!rp_vld_s1) begin
				rp_act_d = 1'b0;
			end
		end else if (in_fire) begin
			if (in_ch.end_of_text) begin
				if (have_held_q) begin
					res_load = 1'b1;
				end
				have_held_d = 1'b0;
				new_len_d   = '0;
				count_d     = '0;
				saw_d       = 1'b0;
				eng_clear   = 1'b1;
			end else if (is_nl) begin
				eng_clear = 1'b1;
				new_len_d = '0;
				if (new_len_q >= LINE_LIMIT) begin
					res_load             = 1'b1;
					res_d                = '0;
					res_d.too_long_error = 1'b1;
					halted_d             = 1'b1;
				end else if (have_held_q &&
					(fin_exact || (fin_prefix && mode_q == MODE_PREFIX))) begin
					saw_d = saw_q | fin_exact;
					if (count_q != COUNT_MAX) begin
						count_d = count_q + 1'b1;
					end
				end else begin
					// no held group, or a different key: this line opens a group
					res_load    = have_held_q;
					have_held_d = 1'b1;
					held_bank_d = wbank;
					held_len_d  = new_len_q;
					held_key_d  = key_final;
					count_d     = COUNT_W'(1);
					saw_d       = 1'b0;
				end
			end else if (new_len_q < LINE_LIMIT) begin
				mem_we    = 1'b1;
				new_len_d = new_len_q + 1'b1;
				step_en   = 1'b1;
			end
		end

		if (cfg_wr_en && (cfg_index == CFG_SKIP_FIELDS || cfg_index == CFG_SKIP_LETTERS) &&
			new_len_q != '0 && !halted_q) begin
			dirty_d = 1'b1;
		end
	end

	// key scanner and byte-wise comparator
	always_comb begin
		logic [1:0]          ph, ph_n;
		logic [FIELDS_W:0]   fc_inc;
		logic [FIELDS_W-1:0] fc_n;
		logic [POS_W-1:0]    lc_n;
		logic                go_letter, is_key, zero, blank;

		zero   = step_byte == CH_NUL;
		blank  = (step_byte == CH_SPACE) || (step_byte == CH_TAB);
		fc_inc = {1'b0, fc_q} + 1'b1;
		ph     = phase_q;
		if ((ph == PH_BLANK || ph == PH_WORD) && fc_q >= skip_fields_q) begin
			ph = PH_LETTER;
		end
		ph_n      = ph;
		fc_n      = fc_q;
		lc_n      = lc_q;
		go_letter = 1'b0;
		is_key    = 1'b0;
		case (ph)
			PH_BLANK: begin
				if (zero) begin
					is_key = 1'b1;
				end else if (!blank) begin
					ph_n = PH_WORD;
				end
			end
			PH_WORD: begin
				if (zero) begin
					is_key = 1'b1;
				end else if (blank) begin
					fc_n = fc_inc[FIELDS_W-1:0];
					if (fc_inc < {1'b0, skip_fields_q}) begin
						ph_n = PH_BLANK;
					end else begin
						go_letter = 1'b1;
					end
				end
			end
			PH_LETTER: go_letter = 1'b1;
			default:   is_key = 1'b1;
		endcase
		if (go_letter) begin
			if (zero || lc_q >= skip_letters_q) begin
				is_key = 1'b1;
			end else begin
				lc_n = lc_q + 1'b1;
				ph_n = PH_LETTER;
			end
		end
		if (is_key) begin
			ph_n = PH_KEY;
		end

		phase_d   = phase_q;
		fc_d      = fc_q;
		lc_d      = lc_q;
		kidx_d    = kidx_q;
		kstart_d  = kstart_q;
		kfound_d  = kfound_q;
		decided_d = decided_q;
		outcome_d = outcome_q;
		if (eng_clear) begin
			phase_d   = PH_BLANK;
			fc_d      = '0;
			lc_d      = '0;
			kidx_d    = '0;
			kfound_d  = 1'b0;
			decided_d = 1'b0;
		end else if (step_en) begin
			phase_d = ph_n;
			fc_d    = fc_n;
			lc_d    = lc_n;
			if (is_key) begin
				kidx_d = kidx_q + 1'b1;
				if (!kfound_q) begin
					kfound_d = 1'b1;
					kstart_d = step_pos;
				end
				if (!decided_q) begin
					if (c_cur != step_byte) begin
						decided_d = 1'b1;
						outcome_d = (c_cur == CH_NUL) ? CMP_PREFIX : CMP_DIFF;
					end else if (c_cur == CH_NUL) begin
						decided_d = 1'b1;
						outcome_d = CMP_EXACT;
					end
				end
			end
		end
	end

	// prefetch the held byte for the next key index
	assign held_sum  = {1'b0, held_key_d} + {1'b0, kidx_d};
	assign inrange_d = held_sum < {1'b0, held_len_d};
	assign raddr_a   = {held_bank_d, held_sum[POS_W-1:0]};
	assign raddr_b   = {wbank, rp_pos_q};
	assign waddr     = {wbank, new_len_q};

	ald_ram #(
		.WIDTH (TEXT_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr),
		.wdata   (in_ch.text_byte),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_fields_q  <= '0;
			skip_letters_q <= '0;
			mode_q         <= '0;
			held_bank_q    <= 1'b0;
			have_held_q    <= 1'b0;
			held_len_q     <= '0;
			held_key_q     <= '0;
			new_len_q      <= '0;
			count_q        <= '0;
			saw_q          <= 1'b0;
			halted_q       <= 1'b0;
			dirty_q        <= 1'b0;
			phase_q        <= PH_BLANK;
			fc_q           <= '0;
			lc_q           <= '0;
			kidx_q         <= '0;
			kstart_q       <= '0;
			kfound_q       <= 1'b0;
			decided_q      <= 1'b0;
			outcome_q      <= CMP_EXACT;
			inrange_q      <= 1'b0;
			rp_act_q       <= 1'b0;
			rp_pos_q       <= '0;
			rp_vld_s1      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SKIP_FIELDS:  skip_fields_q  <= cfg_data[FIELDS_W-1:0];
					CFG_SKIP_LETTERS: skip_letters_q <= cfg_data[POS_W-1:0];
					CFG_MODE_SELECT:  mode_q         <= cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			held_bank_q <= held_bank_d;
			have_held_q <= have_held_d;
			held_len_q  <= held_len_d;
			held_key_q  <= held_key_d;
			new_len_q   <= new_len_d;
			count_q     <= count_d;
			saw_q       <= saw_d;
			halted_q    <= halted_d;
			dirty_q     <= dirty_d;
			phase_q     <= phase_d;
			fc_q        <= fc_d;
			lc_q        <= lc_d;
			kidx_q      <= kidx_d;
			kstart_q    <= kstart_d;
			kfound_q    <= kfound_d;
			decided_q   <= decided_d;
			outcome_q   <= outcome_d;
			inrange_q   <= inrange_d;
			rp_act_q    <= rp_act_d;
			rp_pos_q    <= rp_pos_d;
			rp_vld_s1   <= rp_vld_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rp_pos_s1 <= rp_pos_s1_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.print_line     = res_q.print_line;
	assign out_ch.show_count     = res_q.show_count;
	assign out_ch.repeat_count   = res_q.repeat_count;
	assign out_ch.line_length    = res_q.line_length;
	assign out_ch.too_long_error = res_q.too_long_error;

	// no input item slips in while a rescan owns the scanner
	a_rescan_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		rp_act_q |-> !in_fire) else $error("item accepted during rescan");

	// the line length never passes the storage limit
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		new_len_q <= LINE_LIMIT) else $error("line length past limit");

	// once halted, no further result is produced
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_load) else $error("result after halt");

	// a compare verdict implies the key start was seen
	a_decided_key: assert property (@(posedge clk) disable iff (!arst_n)
		decided_q |-> kfound_q) else $error("verdict without key start");

endmodule

[sv/ald_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module ald_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
